// ===== rtl/core/masked_signature_scanner_core_assert.svh =====
// Assertion macros for the masked signature scanner core.
// Used by the checker module; no other dependencies.
`ifndef MASKED_SIGNATURE_SCANNER_CORE_ASSERT_SVH
`define MASKED_SIGNATURE_SCANNER_CORE_ASSERT_SVH

// Clocked property, ignored while reset is high.
`define MSS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked property that must also hold during reset.
`define MSS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/mss_pkg.sv =====
// Shared types and constants for the masked signature scanner.
// No dependencies.
`default_nettype none
package mss_pkg;

   localparam int MAX_PATTERN = 32;
   localparam int PAT_BYTES   = 32;
   localparam int PAT_REGS    = 4;
   localparam int LEN_W       = 6;
   localparam int ADDR_W      = 48;
   localparam int CNT_W       = 4;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 64;
   localparam int QDEPTH      = 2;
   localparam int QPTR_W      = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int QCNT_W      = $clog2(QDEPTH + 1);

   localparam logic [CNT_W-1:0] COUNT_LIMIT = 4'd9;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_LENGTH = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PAT0   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PAT1   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PAT2   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PAT3   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_CARE   = 3'd5;

   typedef struct packed {
      logic              hit;
      logic [ADDR_W-1:0] start_addr;
      logic              first_scan;
      logic              last_scan;
   } mss_entry_type;

endpackage
`default_nettype wire

// ===== rtl/core/mss_front.sv =====
// Front end: config registers, byte window and masked compare per byte.
// Depends on mss_pkg.
`default_nettype none
module mss_front (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_we,
   input  wire logic [mss_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [mss_pkg::CSR_DATA_W-1:0]   csr_data,
   input  wire logic                             accept,
   input  wire logic [7:0]                       code_byte,
   input  wire logic [mss_pkg::ADDR_W-1:0]       byte_address,
   input  wire logic                             first_of_section,
   input  wire logic                             first_of_scan,
   input  wire logic                             last_of_scan,
   output mss_pkg::mss_entry_type                entry
);
   import mss_pkg::*;

   logic [LEN_W-1:0]               len_ff;
   logic [PAT_REGS-1:0][63:0]      pat_ff;
   logic [PAT_BYTES-1:0]           care_ff;
   logic [MAX_PATTERN-1:0][7:0]    win_ff, win_in;
   logic [LEN_W-1:0]               fill_ff, fill_in;
   logic [7:0]                     pat_byte [PAT_BYTES];
   logic [MAX_PATTERN-1:0]         slot_ok;
   logic                           hit;

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff  <= '0;
         pat_ff  <= '0;
         care_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_LENGTH: len_ff    <= csr_data[LEN_W-1:0];
            CSR_PAT0:   pat_ff[0] <= csr_data;
            CSR_PAT1:   pat_ff[1] <= csr_data;
            CSR_PAT2:   pat_ff[2] <= csr_data;
            CSR_PAT3:   pat_ff[3] <= csr_data;
            CSR_CARE:   care_ff   <= csr_data[PAT_BYTES-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      for (int i = 0; i < PAT_BYTES; i++) begin
         pat_byte[i] = pat_ff[i / 8][(i % 8) * 8 +: 8];
      end
   end

   // window after this byte shifts in; slot 0 is the newest byte
   always_comb begin
      win_in[0] = code_byte;
      for (int j = 1; j < MAX_PATTERN; j++) begin
         win_in[j] = win_ff[j-1];
      end
      if (first_of_section) begin
         fill_in = LEN_W'(1);
      end else if (fill_ff < LEN_W'(MAX_PATTERN)) begin
         fill_in = fill_ff + LEN_W'(1);
      end else begin
         fill_in = fill_ff;
      end
   end

   // slot j pairs with pattern byte len-1-j
   always_comb begin
      logic [LEN_W-1:0] pidx;
      pidx = '0;
      for (int j = 0; j < MAX_PATTERN; j++) begin
         pidx = len_ff - LEN_W'(1) - LEN_W'(j);
         if (LEN_W'(j) >= len_ff) begin
            slot_ok[j] = 1'b1;
         end else begin
            slot_ok[j] = !care_ff[pidx[4:0]] || (win_in[j] == pat_byte[pidx[4:0]]);
         end
      end
      hit = (len_ff != '0) && (len_ff <= LEN_W'(MAX_PATTERN)) &&
            (fill_in >= len_ff) && (&slot_ok);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else if (accept) begin
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         win_ff <= win_in;
      end
   end

   always_comb begin
      entry.hit        = hit;
      entry.start_addr = byte_address - ADDR_W'(len_ff - LEN_W'(1));
      entry.first_scan = first_of_scan;
      entry.last_scan  = last_of_scan;
   end

endmodule
`default_nettype wire

// ===== rtl/core/mss_queue.sv =====
// Short queue of classified bytes between front and back.
// Depends on mss_pkg.
`default_nettype none
module mss_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  mss_pkg::mss_entry_type push_entry,
   output logic                  not_full,
   output logic                  not_empty,
   input  wire logic             pop,
   output mss_pkg::mss_entry_type pop_entry
);
   import mss_pkg::*;

   mss_entry_type         slot_ff [QDEPTH];
   logic [QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]     count_ff, count_in;

   assign not_full  = (count_ff != QCNT_W'(QDEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/core/mss_back.sv =====
// Back end: match counting, first-hit address, early stop, result register.
// Depends on mss_pkg.
`default_nettype none
module mss_back (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       q_valid,
   input  mss_pkg::mss_entry_type          q_entry,
   output logic                            q_pop,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic [mss_pkg::ADDR_W-1:0]      rsp_first_match_address,
   output logic [mss_pkg::CNT_W-1:0]       rsp_match_count,
   output logic                            rsp_unique_match
);
   import mss_pkg::*;

   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic              stop_ff, stop_in;
   logic              emit;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0] rsp_addr_ff;
   logic [CNT_W-1:0]  rsp_cnt_ff;
   logic              rsp_uniq_ff;

   assign q_pop = q_valid && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      cnt_in  = q_entry.first_scan ? '0 : cnt_ff;
      addr_in = q_entry.first_scan ? '0 : addr_ff;
      stop_in = q_entry.first_scan ? 1'b0 : stop_ff;
      emit    = 1'b0;
      if (!stop_in) begin
         if (q_entry.hit) begin
            if (cnt_in == '0) begin
               addr_in = q_entry.start_addr;
            end
            if (cnt_in < COUNT_LIMIT) begin
               cnt_in = cnt_in + CNT_W'(1);
            end
            if (cnt_in >= COUNT_LIMIT) begin
               stop_in = 1'b1;
               emit    = 1'b1;
            end
         end
         if (q_entry.last_scan) begin
            emit = 1'b1;
         end
      end
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (q_pop && emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         addr_ff      <= '0;
         stop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (q_pop) begin
            cnt_ff  <= cnt_in;
            addr_ff <= addr_in;
            stop_ff <= stop_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop && emit) begin
         rsp_addr_ff <= addr_in;
         rsp_cnt_ff  <= cnt_in;
         rsp_uniq_ff <= (cnt_in == CNT_W'(1));
      end
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_first_match_address = rsp_addr_ff;
   assign rsp_match_count         = rsp_cnt_ff;
   assign rsp_unique_match        = rsp_uniq_ff;

endmodule
`default_nettype wire

// ===== rtl/core/masked_signature_scanner_core.sv =====
// Masked byte-pattern scanner. One byte accepted per cycle while the queue is not full.
// A result follows its accepted byte: the front compare writes the queue at the accepting edge,
// then the back end pops the entry once any held result is taken and registers the result.
// Throughput: one byte per cycle, limited by the single-byte window shift and a full queue.
// Reset (synchronous, active high) clears config, window fill, counts, queue
// and result valid; the window bytes themselves are not cleared.
`default_nettype none
module masked_signature_scanner_core (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [mss_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [mss_pkg::CSR_DATA_W-1:0] csr_data,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic [7:0]                     req_code_byte,
   input  wire logic [mss_pkg::ADDR_W-1:0]     req_byte_address,
   input  wire logic                           req_first_of_section,
   input  wire logic                           req_first_of_scan,
   input  wire logic                           req_last_of_scan,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic [mss_pkg::ADDR_W-1:0]          rsp_first_match_address,
   output logic [mss_pkg::CNT_W-1:0]           rsp_match_count,
   output logic                                rsp_unique_match
);
   import mss_pkg::*;

   mss_entry_type front_entry;
   mss_entry_type back_entry;
   logic          accept;
   logic          q_not_full;
   logic          q_not_empty;
   logic          q_pop;

   assign csr_ready = 1'b1;
   assign req_ready = q_not_full;
   assign accept    = req_valid && q_not_full;

   mss_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_valid && csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .accept           (accept),
      .code_byte        (req_code_byte),
      .byte_address     (req_byte_address),
      .first_of_section (req_first_of_section),
      .first_of_scan    (req_first_of_scan),
      .last_of_scan     (req_last_of_scan),
      .entry            (front_entry)
   );

   mss_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (accept),
      .push_entry (front_entry),
      .not_full   (q_not_full),
      .not_empty  (q_not_empty),
      .pop        (q_pop),
      .pop_entry  (back_entry)
   );

   mss_back u_back (
      .clock                   (clock),
      .reset                   (reset),
      .q_valid                 (q_not_empty),
      .q_entry                 (back_entry),
      .q_pop                   (q_pop),
      .rsp_valid               (rsp_valid),
      .rsp_ready               (rsp_ready),
      .rsp_first_match_address (rsp_first_match_address),
      .rsp_match_count         (rsp_match_count),
      .rsp_unique_match        (rsp_unique_match)
   );

endmodule
`default_nettype wire

// ===== rtl/core/mss_checker.sv =====
// Port-level checker for the scanner core, bound to the top level.
// Depends on mss_pkg and masked_signature_scanner_core_assert.svh.
`default_nettype none
`include "masked_signature_scanner_core_assert.svh"
module mss_checker (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_valid,
   input  wire logic                           csr_ready,
   input  wire logic [mss_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [mss_pkg::CSR_DATA_W-1:0] csr_data,
   input  wire logic                           req_valid,
   input  wire logic                           req_ready,
   input  wire logic [7:0]                     req_code_byte,
   input  wire logic [mss_pkg::ADDR_W-1:0]     req_byte_address,
   input  wire logic                           req_first_of_section,
   input  wire logic                           req_first_of_scan,
   input  wire logic                           req_last_of_scan,
   input  wire logic                           rsp_valid,
   input  wire logic                           rsp_ready,
   input  wire logic [mss_pkg::ADDR_W-1:0]     rsp_first_match_address,
   input  wire logic [mss_pkg::CNT_W-1:0]      rsp_match_count,
   input  wire logic                           rsp_unique_match
);
   import mss_pkg::*;

   // held result must not change under backpressure
   `MSS_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_match_count) && $stable(rsp_first_match_address), "result changed while stalled")
   `MSS_ASSERT(a_count_range, clock, reset, rsp_valid |-> rsp_match_count <= COUNT_LIMIT, "match count above limit")
   `MSS_ASSERT_ALWAYS(a_unique, clock, rsp_valid |-> rsp_unique_match == (rsp_match_count == CNT_W'(1)), "unique flag disagrees with count")
   `MSS_ASSERT(a_no_hit_addr, clock, reset, rsp_valid && rsp_match_count == '0 |-> rsp_first_match_address == '0, "address without a match")

endmodule

bind masked_signature_scanner_core mss_checker u_mss_checker (.*);
`default_nettype wire
